/* sv/fhbt_pkg.sv */
// Package for the FNV hashed bucket table: commands, states and hash constants.
// Used by the controller, the datapath and the top level; depends on nothing.
package fhbt_pkg;

	localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
	localparam logic [63:0] FNV_MULT  = 64'h00000100000001B3;

	typedef enum logic [1:0] {
		CMD_LOOKUP = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_DELETE = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_HWAIT,
		ST_READ,
		ST_SCAN,
		ST_WRITE,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic clear_step;
		logic load;
		logic hash_start;
		logic scan_start;
		logic scan_step;
		logic write;
		logic out_load;
	} ctrl_t;

	typedef struct packed {
		logic clear_done;
		logic hash_done;
		logic scan_done;
	} stat_t;

endpackage

/* sv/fnv_hashed_bucket_table.sv */
// Top level of the FNV hashed bucket table: controller plus datapath.
// Depends on fhbt_pkg, fhbt_ctrl and fhbt_dp.
//
//   channel  handshake              words
//   in       in_valid / in_ready    command, key, addr_in, size_in
//   out      out_valid / out_ready  success, addr_out, size_out
//
// A request runs the iterative FNV multiply over the eight key bytes, then one
// read of the way memory port per way and at most one write-back.
// After reset a clearing pass writes zero to all BUCKETS*WAYS slots, one per
// cycle; in_ready is low until it ends.
// The result sits in an output register; a stalled output holds the next request.
module fnv_hashed_bucket_table #(
	parameter int BUCKETS = 1024,
	parameter int WAYS    = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [63:0] key,
	input  logic [63:0] addr_in,
	input  logic [47:0] size_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        success,
	output logic [63:0] addr_out,
	output logic [47:0] size_out
);
	fhbt_pkg::ctrl_t ctrl;
	fhbt_pkg::stat_t stat;

	fhbt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .stat(stat), .ctrl(ctrl));

	fhbt_dp #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_dp (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .stat(stat),
		.command(command), .key(key), .addr_in(addr_in), .size_in(size_in),
		.success(success), .addr_out(addr_out), .size_out(size_out));
endmodule

/* sv/fhbt_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
module fhbt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule

/* sv/fhbt_hash.sv */
// Iterative FNV-1a 64 unit: one byte and one multiply per cycle.
// Depends on fhbt_pkg.
module fhbt_hash (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] key,
	output logic [63:0] hash,
	output logic        done
);
	logic [63:0] h_q;
	logic [63:0] k_q;
	logic [3:0]  cnt_q;
	logic        done_q;
	logic [63:0] mixed;
	logic [63:0] prod;

	assign mixed = h_q ^ {56'd0, k_q[7:0]};

	// multiply by the FNV prime 2^40 + 0x1B3 as shifts and adds
	assign prod = (mixed << 40) + (mixed << 8) + (mixed << 7) + (mixed << 5)
		+ (mixed << 4) + (mixed << 1) + mixed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= 4'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == 4'd1);
			if (start) begin
				cnt_q <= 4'd8;
			end else if (cnt_q != 4'd0) begin
				cnt_q <= cnt_q - 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			h_q <= fhbt_pkg::FNV_BASIS;
			k_q <= key;
		end else if (cnt_q != 4'd0) begin
			h_q <= prod;
			k_q <= {8'd0, k_q[63:8]};
		end
	end

	assign hash = h_q;
	assign done = done_q;
endmodule

/* sv/fhbt_ctrl.sv */
// Controller state machine for the bucket table.
// Depends on fhbt_pkg.
module fhbt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  fhbt_pkg::stat_t     stat,
	output fhbt_pkg::ctrl_t     ctrl
);
	fhbt_pkg::state_t state_q, state_d;
	logic             out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fhbt_pkg::ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		out_valid_d = out_valid_q;
		ctrl        = '0;
		in_ready    = 1'b0;
		if (out_valid_q && out_ready)
			out_valid_d = 1'b0;
		unique case (state_q)
			fhbt_pkg::ST_CLEAR: begin
				ctrl.clear_step = 1'b1;
				if (stat.clear_done)
					state_d = fhbt_pkg::ST_IDLE;
			end
			fhbt_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctrl.load = 1'b1;
					state_d   = fhbt_pkg::ST_HASH;
				end
			end
			fhbt_pkg::ST_HASH: begin
				ctrl.hash_start = 1'b1;
				state_d         = fhbt_pkg::ST_HWAIT;
			end
			fhbt_pkg::ST_HWAIT: begin
				if (stat.hash_done)
					state_d = fhbt_pkg::ST_READ;
			end
			fhbt_pkg::ST_READ: begin
				ctrl.scan_start = 1'b1;
				state_d         = fhbt_pkg::ST_SCAN;
			end
			fhbt_pkg::ST_SCAN: begin
				ctrl.scan_step = 1'b1;
				if (stat.scan_done)
					state_d = fhbt_pkg::ST_WRITE;
			end
			fhbt_pkg::ST_WRITE: begin
				ctrl.write = 1'b1;
				state_d    = fhbt_pkg::ST_OUT;
			end
			fhbt_pkg::ST_OUT: begin
				if (!out_valid_d) begin
					ctrl.out_load = 1'b1;
					out_valid_d   = 1'b1;
					state_d       = fhbt_pkg::ST_IDLE;
				end
			end
			default: state_d = fhbt_pkg::ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;
endmodule

/* sv/fhbt_dp.sv */
// Datapath: request registers, hash unit, way memories and the way scan.
// Depends on fhbt_pkg, fhbt_hash and fhbt_ram; BUCKETS is a power of two.
module fhbt_dp #(
	parameter int BUCKETS = 1024,
	parameter int WAYS    = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  fhbt_pkg::ctrl_t ctrl,
	output fhbt_pkg::stat_t stat,
	input  logic [1:0]      command,
	input  logic [63:0]     key,
	input  logic [63:0]     addr_in,
	input  logic [47:0]     size_in,
	output logic            success,
	output logic [63:0]     addr_out,
	output logic [47:0]     size_out
);
	localparam int SLOTS = BUCKETS * WAYS;
	localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;

	logic [1:0]    cmd_q;
	logic [63:0]   key_q, addr_q;
	logic [47:0]   size_q;
	logic [63:0]   hash;
	logic [AW-1:0] base_q, clr_q, way_q, hit_q, emp_q, ram_addr;
	logic          found_q, has_emp_q;
	logic [63:0]   rk, ra;
	logic [47:0]   rs;
	logic          we;
	logic [AW-1:0] wslot;
	logic [63:0]   wk, wa;
	logic [47:0]   ws;
	logic          hit_now, rd_valid_q;
	logic [AW-1:0] rd_slot_q;
	logic [WW:0]   cnt_q;
	logic [63:0]   ha_q;
	logic [47:0]   hs_q;
	logic [BW-1:0] bidx;
	logic          res_success;
	logic [63:0]   res_addr;
	logic [47:0]   res_size;

	fhbt_hash u_hash (
		.clk   (clk),
		.arst_n(arst_n),
		.start (ctrl.hash_start),
		.key   (key_q),
		.hash  (hash),
		.done  (stat.hash_done)
	);

	assign bidx = BW'(hash & 64'(BUCKETS - 1));

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cmd_q  <= command;
			key_q  <= key;
			addr_q <= addr_in;
			size_q <= size_in;
		end
		if (stat.hash_done)
			base_q <= AW'(AW'(bidx) * AW'(WAYS));
	end

	assign hit_now = rd_valid_q && (rk == key_q) && !found_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			way_q      <= '0;
			cnt_q      <= '0;
			rd_valid_q <= 1'b0;
			found_q    <= 1'b0;
			has_emp_q  <= 1'b0;
			rd_slot_q  <= '0;
			hit_q      <= '0;
			emp_q      <= '0;
			ha_q       <= '0;
			hs_q       <= '0;
		end else begin
			if (ctrl.clear_step)
				clr_q <= clr_q + AW'(1);
			if (ctrl.scan_start) begin
				way_q      <= base_q + AW'(1);
				rd_slot_q  <= base_q;
				cnt_q      <= (WW + 1)'(WAYS);
				rd_valid_q <= 1'b1;
				found_q    <= 1'b0;
				has_emp_q  <= 1'b0;
			end else if (ctrl.scan_step) begin
				way_q     <= way_q + AW'(1);
				rd_slot_q <= way_q;
				cnt_q     <= cnt_q - (WW + 1)'(1);
				if (hit_now) begin
					found_q <= 1'b1;
					hit_q   <= rd_slot_q;
					ha_q    <= ra;
					hs_q    <= rs;
				end else if (!found_q && rk == 64'd0 && !has_emp_q) begin
					has_emp_q <= 1'b1;
					emp_q     <= rd_slot_q;
				end
			end
		end
	end

	assign stat.scan_done  = ctrl.scan_step && (cnt_q == (WW + 1)'(1));
	assign stat.clear_done = (clr_q == AW'(SLOTS - 1));

	always_comb begin
		we    = 1'b0;
		wslot = hit_q;
		wk    = key_q;
		wa    = addr_q;
		ws    = size_q;
		if (ctrl.clear_step) begin
			we    = 1'b1;
			wslot = clr_q;
			wk    = '0;
			wa    = '0;
			ws    = '0;
		end else if (ctrl.write) begin
			unique case (cmd_q)
				fhbt_pkg::CMD_INSERT: begin
					we    = found_q || has_emp_q;
					wslot = found_q ? hit_q : emp_q;
				end
				fhbt_pkg::CMD_DELETE: begin
					we = found_q;
					wk = '0;
					wa = '0;
					ws = '0;
				end
				default: we = 1'b0;
			endcase
		end
	end

	assign ram_addr = we ? wslot : ((ctrl.scan_start) ? base_q : way_q);

	fhbt_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_keys (
		.clk(clk), .we(we), .addr(ram_addr), .wdata(wk), .rdata(rk));
	fhbt_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_addrs (
		.clk(clk), .we(we), .addr(ram_addr), .wdata(wa), .rdata(ra));
	fhbt_ram #(.WIDTH(48), .DEPTH(SLOTS)) u_sizes (
		.clk(clk), .we(we), .addr(ram_addr), .wdata(ws), .rdata(rs));

	always_comb begin
		res_success = 1'b0;
		res_addr    = '0;
		res_size    = '0;
		unique case (cmd_q)
			fhbt_pkg::CMD_LOOKUP: begin
				res_success = found_q;
				if (found_q) begin
					res_addr = ha_q;
					res_size = hs_q;
				end
			end
			fhbt_pkg::CMD_INSERT: res_success = found_q || has_emp_q;
			fhbt_pkg::CMD_DELETE: res_success = found_q;
			default: res_success = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			success  <= res_success;
			addr_out <= res_addr;
			size_out <= res_size;
		end
	end
endmodule

/* sv/fhbt_checker.sv */
// Port-level checker for the bucket table, bound to the top level.
// Depends only on the top-level ports.
module fhbt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        success,
	input logic [63:0] addr_out,
	input logic [47:0] size_out
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(addr_out) && $stable(success))
		else $error("result dropped while stalled");
	a_no_accept_after: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accepted back to back");
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !success |-> addr_out == 64'd0 && size_out == 48'd0)
		else $error("miss carries data");
	a_ready_gap: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result without a request in flight");
endmodule

bind fnv_hashed_bucket_table fhbt_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .success(success),
	.addr_out(addr_out), .size_out(size_out));

/* tb/tb_fnv_hashed_bucket_table.sv */
// Testbench for the FNV hashed bucket table: lookup, insert and delete requests
// are checked against an in-bench model of the bucket store. Depends on fhbt_pkg
// and fnv_hashed_bucket_table.
module tb_fnv_hashed_bucket_table;

	localparam int BUCKETS = 1024;
	localparam int WAYS = 8;
	localparam int SLOTS = BUCKETS * WAYS;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct {
		logic        success;
		logic [63:0] addr;
		logic [47:0] size;
	} reply_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_ready;
	logic [1:0]  command = fhbt_pkg::CMD_LOOKUP;
	logic [63:0] key = '0;
	logic [63:0] addr_in = '0;
	logic [47:0] size_in = '0;
	logic        out_valid;
	logic        out_ready = 0;
	logic        success;
	logic [63:0] addr_out;
	logic [47:0] size_out;

	logic [63:0] model_keys [SLOTS];
	logic [63:0] model_addrs [SLOTS];
	logic [47:0] model_sizes [SLOTS];
	reply_t      pending_replies [$];
	logic [63:0] known_keys [$];
	int          errors = 0;
	int          replies_seen = 0;
	longint      cycle_count = 0;
	bit          calm = 0;
	int          hold_off = 0;
	bit          long_stall = 0;

	fnv_hashed_bucket_table #(.BUCKETS(BUCKETS), .WAYS(WAYS)) dut (.*);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout at %0t, %0d replies outstanding", $time, pending_replies.size());
			$display("FAIL");
			$finish;
		end
	end

	function automatic logic [63:0] fnv_hash(logic [63:0] k);
		logic [63:0] h;
		h = fhbt_pkg::FNV_BASIS;
		for (int b = 0; b < 8; b++) begin
			h = h ^ {56'd0, k[8*b +: 8]};
			h = h * fhbt_pkg::FNV_MULT;
		end
		return h;
	endfunction

	function automatic reply_t apply_request(fhbt_pkg::cmd_t c, logic [63:0] k,
			logic [63:0] a, logic [47:0] s);
		int base;
		int hit;
		int empty;
		reply_t r;
		base = int'(fnv_hash(k) % BUCKETS) * WAYS;
		hit = -1;
		empty = -1;
		r = '{1'b0, 64'd0, 48'd0};
		for (int w = 0; w < WAYS; w++) begin
			if (hit < 0 && model_keys[base + w] == k) hit = base + w;
			if (hit < 0 && empty < 0 && model_keys[base + w] == 0) empty = base + w;
		end
		case (c)
			fhbt_pkg::CMD_LOOKUP:
				if (hit >= 0) r = '{1'b1, model_addrs[hit], model_sizes[hit]};
			fhbt_pkg::CMD_INSERT: if (hit >= 0 || empty >= 0) begin
				if (hit < 0) hit = empty;
				model_keys[hit] = k;
				model_addrs[hit] = a;
				model_sizes[hit] = s;
				r.success = 1;
			end
			fhbt_pkg::CMD_DELETE: if (hit >= 0) begin
				model_keys[hit] = 0;
				model_addrs[hit] = 0;
				model_sizes[hit] = 0;
				r.success = 1;
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic send_word(fhbt_pkg::cmd_t c, logic [63:0] k, logic [63:0] a,
			logic [47:0] s);
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid <= 1;
		command <= c;
		key <= k;
		addr_in <= a;
		size_in <= s;
		do @(posedge clk); while (!in_ready);
		pending_replies.push_back(apply_request(c, k, a, s));
		if (c == fhbt_pkg::CMD_INSERT) known_keys.push_back(k);
	endtask

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			reply_t e;
			replies_seen++;
			if (pending_replies.size() == 0) begin
				errors++;
				$display("%0t: unexpected reply success=%0b addr=%h size=%h",
					$time, success, addr_out, size_out);
			end else begin
				e = pending_replies.pop_front();
				if (success !== e.success) begin
					errors++;
					$display("%0t: success expected %0b got %0b", $time, e.success, success);
				end
				if (addr_out !== e.addr) begin
					errors++;
					$display("%0t: addr_out expected %h got %h", $time, e.addr, addr_out);
				end
				if (size_out !== e.size) begin
					errors++;
					$display("%0t: size_out expected %h got %h", $time, e.size, size_out);
				end
			end
		end
	end

	// receiver: random stall bursts, or a long hold-off when requested
	always @(posedge clk) begin
		if (long_stall) out_ready <= 0;
		else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ready <= 0;
		end else if (calm) out_ready <= 1;
		else if ($urandom_range(0, 4) == 0) begin
			out_ready <= 0;
			hold_off <= $urandom_range(0, 18);
		end else out_ready <= 1;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] pick_key();
		if (known_keys.size() > 0 && $urandom_range(0, 3) != 0)
			return known_keys[$urandom_range(0, known_keys.size() - 1)];
		return rand64();
	endfunction

	task automatic test_directed();
		send_word(fhbt_pkg::CMD_LOOKUP, 64'd0, 64'd0, 48'd0);
		send_word(fhbt_pkg::CMD_INSERT, 64'd0, '1, '1);
		send_word(fhbt_pkg::CMD_LOOKUP, 64'd0, 64'd0, 48'd0);
		send_word(fhbt_pkg::CMD_DELETE, 64'd0, 64'd0, 48'd0);
		send_word(fhbt_pkg::CMD_INSERT, '1, '1, '1);
		send_word(fhbt_pkg::CMD_LOOKUP, '1, 64'd0, 48'd0);
		send_word(fhbt_pkg::CMD_INSERT, '1, 64'h1234, 48'h5678);
		send_word(fhbt_pkg::CMD_LOOKUP, '1, 64'd0, 48'd0);
		send_word(fhbt_pkg::CMD_NONE, '1, '1, '1);
		send_word(fhbt_pkg::CMD_DELETE, '1, 64'd0, 48'd0);
		send_word(fhbt_pkg::CMD_DELETE, '1, 64'd0, 48'd0);
		send_word(fhbt_pkg::CMD_LOOKUP, '1, 64'd0, 48'd0);
		send_word(fhbt_pkg::CMD_LOOKUP, 64'h8000_0000_0000_0001, 64'd0, 48'd0);
	endtask

	// fill one bucket past capacity with keys that share a hash bucket
	task automatic test_full_bucket();
		logic [63:0] k;
		logic [9:0] target;
		int n;
		target = 10'(fnv_hash(64'h1) % BUCKETS);
		n = 0;
		k = 64'h1;
		while (n < WAYS + 2) begin
			if (fnv_hash(k) % BUCKETS == target) begin
				send_word(fhbt_pkg::CMD_INSERT, k, rand64(), {$urandom, 16'hffff});
				n++;
			end
			k++;
		end
		send_word(fhbt_pkg::CMD_LOOKUP, 64'h1, 64'd0, 48'd0);
		send_word(fhbt_pkg::CMD_DELETE, 64'h1, 64'd0, 48'd0);
		send_word(fhbt_pkg::CMD_INSERT, k - 1, 64'hdead, 48'hbeef);
		send_word(fhbt_pkg::CMD_LOOKUP, k - 1, 64'd0, 48'd0);
	endtask

	task automatic test_backpressure();
		fork
			begin
				long_stall = 1;
				repeat (300) @(posedge clk);
				long_stall = 0;
			end
		join_none
		repeat (20) send_word(fhbt_pkg::CMD_INSERT, rand64(), rand64(),
			48'({$urandom, $urandom} >> 16));
	endtask

	task automatic test_random(int count);
		fhbt_pkg::cmd_t c;
		for (int i = 0; i < count; i++) begin
			if (i == count - count / 5) calm = 1;
			c = fhbt_pkg::cmd_t'($urandom_range(0, 15) == 0 ? 3 : $urandom_range(0, 2));
			send_word(c, pick_key(), rand64(), 48'({$urandom, $urandom}));
		end
	endtask

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			model_keys[i] = 0;
			model_addrs[i] = 0;
			model_sizes[i] = 0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1;
		test_directed();
		test_full_bucket();
		test_backpressure();
		test_random(600);
		in_valid <= 0;
		while (pending_replies.size() > 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("covered %0d replies: lookups, inserts, deletes, key zero, full bucket,",
			replies_seen);
		$display("unused command and a long output stall");
		if (errors == 0 && pending_replies.size() == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end
endmodule
